// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the body extractor.
// Depends on nothing; simulation builds get checks, SYNTH builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("implication check failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// ----- sv/hrbe_pkg.sv -----
// Package for the HTTP response body extractor: payload structs, phase
// enum, header match text and hex digit decode. No dependencies.
package hrbe_pkg;

	localparam int CHUNK_SIZE_BITS = 32;
	localparam int ENC_LEN = 26;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_T     = 8'h54;

	typedef logic [CHUNK_SIZE_BITS-1:0] cnt_t;
	localparam cnt_t CNT_ONE = cnt_t'(1);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PLAIN,
		PH_SIZE,
		PH_SKIP,
		PH_DATA,
		PH_ENDED
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_response;
	} in_item_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_valid;
		logic       done_res;
		logic       was_chunked;
		logic       header_seen;
		logic       size_overflow;
	} out_item_t;

	// Per-byte step control shared by the matcher and the phase machine
	typedef struct packed {
		logic       fire;
		logic       last;
		logic [7:0] rx_byte;
	} step_t;

	// Header matcher status for the byte in flight
	typedef struct packed {
		logic term_hit;   // this byte completes CR LF CR LF
		logic chunked;    // chunked flag after this byte
	} hdr_stat_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// "Transfer-Encoding: chunked", one character per index
	function automatic logic [7:0] enc_char(input logic [4:0] idx);
		logic [7:0] ch;
		case (idx)
			5'd0:  ch = "T";
			5'd1:  ch = "r";
			5'd2:  ch = "a";
			5'd3:  ch = "n";
			5'd4:  ch = "s";
			5'd5:  ch = "f";
			5'd6:  ch = "e";
			5'd7:  ch = "r";
			5'd8:  ch = "-";
			5'd9:  ch = "E";
			5'd10: ch = "n";
			5'd11: ch = "c";
			5'd12: ch = "o";
			5'd13: ch = "d";
			5'd14: ch = "i";
			5'd15: ch = "n";
			5'd16: ch = "g";
			5'd17: ch = ":";
			5'd18: ch = " ";
			5'd19: ch = "c";
			5'd20: ch = "h";
			5'd21: ch = "u";
			5'd22: ch = "n";
			5'd23: ch = "k";
			5'd24: ch = "e";
			5'd25: ch = "d";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// ASCII hex digit decode, either case
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			h.val = c[3:0];
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// ----- sv/hrbe_hdr_match.sv -----
// Header text matchers: CR LF CR LF terminator and the chunked encoding line.
// Depends on hrbe_pkg.
module hrbe_hdr_match (
	input  logic               clk,
	input  logic               arst_n,
	input  hrbe_pkg::step_t    step,
	input  logic               in_header,
	output hrbe_pkg::hdr_stat_t stat
);

	logic [4:0] enc_q, enc_d;
	logic [1:0] term_q, term_d;
	logic       chunked_q, chunked_d;
	logic [7:0] term_char;
	logic       term_hit;

	// Encoding text match, restarting on a fresh 'T'
	always_comb begin
		enc_d     = enc_q;
		chunked_d = chunked_q;
		if (step.rx_byte == hrbe_pkg::enc_char(enc_q)) begin
			if (enc_q == 5'(hrbe_pkg::ENC_LEN - 1)) begin
				enc_d     = 5'd0;
				chunked_d = 1'b1;
			end else begin
				enc_d = enc_q + 5'd1;
			end
		end else begin
			enc_d = (step.rx_byte == hrbe_pkg::CHAR_T) ? 5'd1 : 5'd0;
		end
	end

	// Terminator match: CR on even positions, LF on odd
	assign term_char = term_q[0] ? hrbe_pkg::CHAR_LF : hrbe_pkg::CHAR_CR;

	always_comb begin
		term_d   = term_q;
		term_hit = 1'b0;
		if (step.rx_byte == term_char) begin
			if (term_q == 2'd3) begin
				term_d   = 2'd0;
				term_hit = 1'b1;
			end else begin
				term_d = term_q + 2'd1;
			end
		end else begin
			term_d = (step.rx_byte == hrbe_pkg::CHAR_CR) ? 2'd1 : 2'd0;
		end
	end

	// Flag as seen after this byte; holds outside the header
	assign stat = '{term_hit: term_hit, chunked: (in_header ? chunked_d : chunked_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q     <= 5'd0;
			term_q    <= 2'd0;
			chunked_q <= 1'b0;
		end else if (step.fire) begin
			if (step.last) begin
				enc_q     <= 5'd0;
				term_q    <= 2'd0;
				chunked_q <= 1'b0;
			end else if (in_header) begin
				enc_q     <= enc_d;
				term_q    <= term_d;
				chunked_q <= chunked_d;
			end
		end
	end

endmodule

// ----- sv/hrbe_chunk_fsm.sv -----
// Phase machine: plain body pass-through and chunk size / data / skip decode.
// Depends on hrbe_pkg; takes header status from hrbe_hdr_match.
module hrbe_chunk_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  hrbe_pkg::step_t     step,
	input  hrbe_pkg::hdr_stat_t hdr,
	output logic                in_header,
	output hrbe_pkg::out_item_t result,
	output logic                has_result
);

	hrbe_pkg::phase_t ph_q, ph_d;
	hrbe_pkg::cnt_t   rem_q, rem_d;
	logic [1:0]       skip_q, skip_d, skip_dec;
	logic             seen_q, seen_d;
	logic             ovf_q, ovf_d;
	hrbe_pkg::hex_t   hex;
	logic             pass;

	assign hex       = hrbe_pkg::hex_decode(step.rx_byte);
	assign skip_dec  = (skip_q != 2'd0) ? (skip_q - 2'd1) : 2'd0;
	assign in_header = (ph_q == hrbe_pkg::PH_HEADER);

	// Next state
	always_comb begin
		ph_d   = ph_q;
		rem_d  = rem_q;
		skip_d = skip_q;
		seen_d = seen_q;
		ovf_d  = ovf_q;
		case (ph_q)
			hrbe_pkg::PH_HEADER: begin
				if (hdr.term_hit) begin
					ph_d   = hdr.chunked ? hrbe_pkg::PH_SIZE : hrbe_pkg::PH_PLAIN;
					rem_d  = '0;
					seen_d = 1'b0;
				end
			end
			hrbe_pkg::PH_PLAIN: begin
			end
			hrbe_pkg::PH_SIZE: begin
				if (hex.ok) begin
					// a digit that would push bits off the top is an overflow
					if (rem_q[hrbe_pkg::CHUNK_SIZE_BITS-1 -: 4] != 4'd0) begin
						ovf_d = 1'b1;
						ph_d  = hrbe_pkg::PH_ENDED;
					end else begin
						rem_d  = {rem_q[hrbe_pkg::CHUNK_SIZE_BITS-5:0], hex.val};
						seen_d = 1'b1;
					end
				end else if (step.rx_byte == hrbe_pkg::CHAR_SPACE && !seen_q) begin
					// leading space skipped
				end else if (!seen_q || rem_q == '0) begin
					ph_d = hrbe_pkg::PH_ENDED;
				end else begin
					skip_d = 2'd1;
					ph_d   = hrbe_pkg::PH_SKIP;
				end
			end
			hrbe_pkg::PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 2'd0) begin
					if (rem_q != '0) begin
						ph_d = hrbe_pkg::PH_DATA;
					end else begin
						ph_d   = hrbe_pkg::PH_SIZE;
						seen_d = 1'b0;
					end
				end
			end
			hrbe_pkg::PH_DATA: begin
				rem_d = rem_q - hrbe_pkg::CNT_ONE;
				if (rem_q == hrbe_pkg::CNT_ONE) begin
					skip_d = 2'd2;
					ph_d   = hrbe_pkg::PH_SKIP;
				end
			end
			default: begin
			end
		endcase
	end

	// Outputs for the byte in flight; flags show the state after it
	always_comb begin
		pass                 = (ph_q == hrbe_pkg::PH_PLAIN) || (ph_q == hrbe_pkg::PH_DATA);
		result.body_byte     = pass ? step.rx_byte : 8'h00;
		result.body_valid    = pass;
		result.done_res      = step.last;
		result.was_chunked   = hdr.chunked;
		result.header_seen   = (ph_d != hrbe_pkg::PH_HEADER);
		result.size_overflow = ovf_d;
		has_result           = step.fire && (pass || step.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= hrbe_pkg::PH_HEADER;
			rem_q  <= '0;
			skip_q <= 2'd0;
			seen_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (step.fire) begin
			if (step.last) begin
				ph_q   <= hrbe_pkg::PH_HEADER;
				rem_q  <= '0;
				skip_q <= 2'd0;
				seen_q <= 1'b0;
				ovf_q  <= 1'b0;
			end else begin
				ph_q   <= ph_d;
				rem_q  <= rem_d;
				skip_q <= skip_d;
				seen_q <= seen_d;
				ovf_q  <= ovf_d;
			end
		end
	end

endmodule

// ----- sv/http_response_body_extractor.sv -----
// HTTP response body extractor, top level: input register, header matcher,
// phase machine and result register. Depends on hrbe_pkg, assert_macros.svh.
//
// Usage:
//   src channel: one response byte per transfer (rx_byte, end_of_response).
//   res channel: one result per transfer for each body byte that passes and
//   for the final byte of a response (done_res = 1), flags show the state
//   after that byte. Header bytes, chunk size lines and chunk trailers give
//   no result unless they are the final byte.
//   Path: a byte taken from src passes the input register, then the result
//   register, before its result is on res. Throughput: one byte per cycle
//   while the result register is free or being drained, set by the per-byte
//   state update of the phase machine.
//   Stall: when res_stall holds on a full result register, that register
//   keeps its value and src_stall rises once the input register is also
//   full, so two bytes are held without loss.
//   Reset: arst_n clears both registers' valid bits and all parse state;
//   the block then waits for the start of a header. The final byte of each
//   response also returns the parse state to its reset values.
`include "assert_macros.svh"

module http_response_body_extractor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  hrbe_pkg::in_item_t  src_data,
	output logic                res_valid,
	input  logic                res_stall,
	output hrbe_pkg::out_item_t res_data
);

	logic                valid_s1;
	hrbe_pkg::in_item_t  item_s1;
	logic                adv;
	hrbe_pkg::step_t     step;
	hrbe_pkg::hdr_stat_t hdr;
	logic                in_header;
	hrbe_pkg::out_item_t result;
	logic                has_result;
	logic                res_valid_q;
	hrbe_pkg::out_item_t res_q;

	// Stage 1 moves on whenever the result register is free or being drained
	assign adv       = !res_valid_q || !res_stall;
	assign src_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			item_s1 <= src_data;
		end
	end

	assign step.fire    = valid_s1 && adv;
	assign step.last    = item_s1.end_of_response;
	assign step.rx_byte = item_s1.rx_byte;

	hrbe_hdr_match u_hdr (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_header (in_header),
		.stat      (hdr)
	);

	hrbe_chunk_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.hdr        (hdr),
		.in_header  (in_header),
		.result     (result),
		.has_result (has_result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Body bytes only come after the header terminator
	`ASSERT_IMPLY(a_body_after_hdr, clk, arst_n,
		res_valid && res_data.body_valid, res_data.header_seen)
	// A result that carries no byte is the end of a response
	`ASSERT_IMPLY(a_empty_is_last, clk, arst_n,
		res_valid && !res_data.body_valid, res_data.done_res)
	// Size overflow only arises in chunked decoding
	`ASSERT_IMPLY(a_ovf_chunked, clk, arst_n,
		res_valid && res_data.size_overflow, res_data.was_chunked && res_data.header_seen)
	// Input back-pressure only while the input register holds a byte
	`ASSERT_IMPLY(a_stall_full, clk, arst_n, src_stall, valid_s1 && res_valid_q)

endmodule
